// File: rtl/sgpb_pkg.sv
// ============================================================================
// Spatial grid binner package
// Shared codes, field widths, defaults and a helper function.
// ============================================================================
package sgpb_pkg;

    // Request codes carried on req_type.
    typedef enum logic [1:0] {
        REQ_REGISTER   = 2'd0,
        REQ_UNREGISTER = 2'd1,
        REQ_CLEAR      = 2'd2,
        REQ_READ       = 2'd3
    } req_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OUTSIDE   = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    // Configuration register indexes.
    localparam logic [2:0] CFG_MIN_X     = 3'd0;
    localparam logic [2:0] CFG_MIN_Y     = 3'd1;
    localparam logic [2:0] CFG_CELL_EDGE = 3'd2;
    localparam logic [2:0] CFG_RES_X     = 3'd3;
    localparam logic [2:0] CFG_RES_Y     = 3'd4;

    // Fixed field widths.
    localparam int POS_W      = 24;
    localparam int CS_W       = 23;
    localparam int RES_W      = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int EFF_W      = 11;          // holds a column or row count up to 2047
    localparam int Q_W        = POS_W + 1;   // magnitude of a position difference
    localparam int QUEUE_DEPTH = 2;

    // Reset values of the configuration registers.
    localparam logic [POS_W-1:0] MIN_X_RST     = '0;
    localparam logic [POS_W-1:0] MIN_Y_RST     = '0;
    localparam logic [CS_W-1:0]  CELL_EDGE_RST = 23'd256;
    localparam logic [RES_W-1:0] RES_X_RST     = 7'd64;
    localparam logic [RES_W-1:0] RES_Y_RST     = 7'd64;

    // Default parameter values.
    localparam int MAX_COLS_DEF   = 64;
    localparam int MAX_ROWS_DEF   = 64;
    localparam int SLOT_LIMIT_DEF = 15;
    localparam int ID_WIDTH_DEF   = 16;

    // Bits needed to index n entries, never less than one.
    function automatic int bits_for(input int n);
        int w;
        begin
            w = (n > 1) ? $clog2(n) : 1;
            return w;
        end
    endfunction

endpackage

// File: rtl/sgpb_queue.sv
// ============================================================================
// Spatial grid binner command queue
// Small FIFO that decouples the classifying front end from the cell engine.
// ============================================================================
module sgpb_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = sgpb_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             q_full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             q_empty
);

    localparam int PTR_W = sgpb_pkg::bits_for(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;
    logic             do_wr;
    logic             do_rd;

    assign q_full  = (fill_reg == CNT_W'(DEPTH));
    assign q_empty = (fill_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slots_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

// File: rtl/sgpb_front.sv
// ============================================================================
// Spatial grid binner front end
// Takes requests, maps positions to cells with two bit-serial dividers and
// queues a classified command for the cell engine.
// ============================================================================
module sgpb_front #(
    parameter int MAX_COLS   = sgpb_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS   = sgpb_pkg::MAX_ROWS_DEF,
    parameter int SLOT_LIMIT = sgpb_pkg::SLOT_LIMIT_DEF,
    parameter int ID_WIDTH   = sgpb_pkg::ID_WIDTH_DEF
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           push,
    output logic                                           busy,
    input  logic [1:0]                                     req_type,
    input  logic [sgpb_pkg::POS_W-1:0]                     pos_x,
    input  logic [sgpb_pkg::POS_W-1:0]                     pos_y,
    input  logic [ID_WIDTH-1:0]                            particle_id,
    input  logic [sgpb_pkg::bits_for(SLOT_LIMIT+1)-1:0]    slot_sel,
    input  logic [sgpb_pkg::POS_W-1:0]                     min_x,
    input  logic [sgpb_pkg::POS_W-1:0]                     min_y,
    input  logic [sgpb_pkg::CS_W-1:0]                      cell_edge,
    input  logic [sgpb_pkg::RES_W-1:0]                     res_x,
    input  logic [sgpb_pkg::RES_W-1:0]                     res_y,
    output logic                                           cmd_push,
    output logic [2+1+sgpb_pkg::bits_for(MAX_COLS*MAX_ROWS)+ID_WIDTH
                  +sgpb_pkg::bits_for(SLOT_LIMIT+1)-1:0]   cmd_data,
    input  logic                                           cmd_full
);

    localparam int Q_W    = sgpb_pkg::Q_W;
    localparam int CS_W   = sgpb_pkg::CS_W;
    localparam int EFF_W  = sgpb_pkg::EFF_W;
    localparam int CIDX_W = sgpb_pkg::bits_for(MAX_COLS * MAX_ROWS);
    localparam int CNT_W  = sgpb_pkg::bits_for(SLOT_LIMIT + 1);
    localparam int X_W    = sgpb_pkg::bits_for(MAX_COLS);
    localparam int Y_W    = sgpb_pkg::bits_for(MAX_ROWS);
    localparam int STEP_W = $clog2(Q_W + 1);

    typedef enum logic [2:0] {
        F_IDLE,
        F_DIV,
        F_CLS,
        F_MUL,
        F_PUSH
    } fstate_t;

    fstate_t           state_reg;
    logic [STEP_W-1:0] step_reg;
    logic [1:0]        req_reg;
    logic [ID_WIDTH-1:0] id_reg;
    logic [CNT_W-1:0]  sel_reg;
    logic [CS_W-1:0]   den_reg;
    logic              neg_x_reg;
    logic              neg_y_reg;
    logic [Q_W-1:0]    quo_x_reg;
    logic [Q_W-1:0]    quo_y_reg;
    logic [CS_W-1:0]   rem_x_reg;
    logic [CS_W-1:0]   rem_y_reg;
    logic [EFF_W-1:0]  cols_reg;
    logic [EFF_W-1:0]  rows_reg;
    logic [X_W-1:0]    cx_reg;
    logic [Y_W-1:0]    cy_reg;
    logic              outside_reg;
    logic [CIDX_W-1:0] cidx_reg;

    logic [Q_W:0]      num_x;
    logic [Q_W:0]      num_y;
    logic [CS_W+Q_W-1:0] div_x;
    logic [CS_W+Q_W-1:0] div_y;
    logic [Q_W:0]      mag_x;
    logic [Q_W:0]      mag_y;
    logic [EFF_W-1:0]  cols_eff;
    logic [EFF_W-1:0]  rows_eff;

    // One restoring step: shift in the next dividend bit, subtract when it fits.
    function automatic logic [CS_W+Q_W-1:0] div_step(
        input logic [CS_W-1:0] rem,
        input logic [Q_W-1:0]  quo,
        input logic [CS_W-1:0] den
    );
        logic [CS_W:0]   trial;
        logic            fits;
        logic [CS_W-1:0] rem_n;
        begin
            trial = {rem, quo[Q_W-1]};
            fits  = (trial >= {1'b0, den});
            rem_n = fits ? CS_W'(trial - {1'b0, den}) : trial[CS_W-1:0];
            return {rem_n, quo[Q_W-2:0], fits};
        end
    endfunction

    // Resolution 0 counts as one; anything above the grid bound saturates.
    function automatic logic [EFF_W-1:0] eff_res(input logic [sgpb_pkg::RES_W-1:0] r,
                                                 input logic [EFF_W-1:0] max_v);
        logic [EFF_W-1:0] v;
        begin
            v = EFF_W'(r);
            if (r == '0)
            begin
                v = EFF_W'(1);
            end
            else if (v > max_v)
            begin
                v = max_v;
            end
            return v;
        end
    endfunction

    assign num_x    = {{2{pos_x[sgpb_pkg::POS_W-1]}}, pos_x}
                    - {{2{min_x[sgpb_pkg::POS_W-1]}}, min_x};
    assign num_y    = {{2{pos_y[sgpb_pkg::POS_W-1]}}, pos_y}
                    - {{2{min_y[sgpb_pkg::POS_W-1]}}, min_y};
    assign div_x    = div_step(rem_x_reg, quo_x_reg, den_reg);
    assign div_y    = div_step(rem_y_reg, quo_y_reg, den_reg);
    // Floor division of a negative value rounds the magnitude up.
    assign mag_x    = {1'b0, quo_x_reg} + (Q_W+1)'(neg_x_reg && (rem_x_reg != '0));
    assign mag_y    = {1'b0, quo_y_reg} + (Q_W+1)'(neg_y_reg && (rem_y_reg != '0));
    assign cols_eff = eff_res(res_x, EFF_W'(MAX_COLS));
    assign rows_eff = eff_res(res_y, EFF_W'(MAX_ROWS));

    assign busy     = (state_reg != F_IDLE);
    assign cmd_push = (state_reg == F_PUSH);
    assign cmd_data = {req_reg, outside_reg, cidx_reg, id_reg, sel_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (push)
                    begin
                        req_reg   <= req_type;
                        id_reg    <= particle_id;
                        sel_reg   <= slot_sel;
                        den_reg   <= (cell_edge == '0) ? CS_W'(1) : cell_edge;
                        neg_x_reg <= num_x[Q_W];
                        neg_y_reg <= num_y[Q_W];
                        quo_x_reg <= num_x[Q_W] ? Q_W'(-num_x) : num_x[Q_W-1:0];
                        quo_y_reg <= num_y[Q_W] ? Q_W'(-num_y) : num_y[Q_W-1:0];
                        rem_x_reg <= '0;
                        rem_y_reg <= '0;
                        cols_reg  <= cols_eff;
                        rows_reg  <= rows_eff;
                        step_reg  <= '0;
                        state_reg <= F_DIV;
                    end
                end
                F_DIV:
                begin
                    {rem_x_reg, quo_x_reg} <= div_x;
                    {rem_y_reg, quo_y_reg} <= div_y;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(Q_W - 1))
                    begin
                        state_reg <= F_CLS;
                    end
                end
                F_CLS:
                begin
                    outside_reg <= (neg_x_reg && (mag_x != '0))
                                || (neg_y_reg && (mag_y != '0))
                                || (!neg_x_reg && (mag_x >= (Q_W+1)'(cols_reg)))
                                || (!neg_y_reg && (mag_y >= (Q_W+1)'(rows_reg)));
                    if (neg_x_reg)
                    begin
                        cx_reg <= '0;
                    end
                    else if (mag_x >= (Q_W+1)'(cols_reg))
                    begin
                        cx_reg <= X_W'(cols_reg - 1'b1);
                    end
                    else
                    begin
                        cx_reg <= mag_x[X_W-1:0];
                    end
                    if (neg_y_reg)
                    begin
                        cy_reg <= '0;
                    end
                    else if (mag_y >= (Q_W+1)'(rows_reg))
                    begin
                        cy_reg <= Y_W'(rows_reg - 1'b1);
                    end
                    else
                    begin
                        cy_reg <= mag_y[Y_W-1:0];
                    end
                    state_reg <= F_MUL;
                end
                F_MUL:
                begin
                    cidx_reg  <= CIDX_W'(cx_reg) + CIDX_W'(CIDX_W'(cy_reg) * CIDX_W'(cols_reg));
                    state_reg <= F_PUSH;
                end
                F_PUSH:
                begin
                    if (!cmd_full)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/sgpb_back.sv
// ============================================================================
// Spatial grid binner cell engine
// Holds the per-cell counts and handle slots and carries out queued commands.
// ============================================================================
module sgpb_back #(
    parameter int MAX_COLS   = sgpb_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS   = sgpb_pkg::MAX_ROWS_DEF,
    parameter int SLOT_LIMIT = sgpb_pkg::SLOT_LIMIT_DEF,
    parameter int ID_WIDTH   = sgpb_pkg::ID_WIDTH_DEF
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    output logic                                           init_busy,
    input  logic [2+1+sgpb_pkg::bits_for(MAX_COLS*MAX_ROWS)+ID_WIDTH
                  +sgpb_pkg::bits_for(SLOT_LIMIT+1)-1:0]   cmd_data,
    input  logic                                           cmd_empty,
    output logic                                           cmd_pop,
    output logic                                           empty,
    input  logic                                           pop,
    output logic [1:0]                                     status,
    output logic [sgpb_pkg::bits_for(MAX_COLS*MAX_ROWS)-1:0] bin_index,
    output logic [sgpb_pkg::bits_for(SLOT_LIMIT+1)-1:0]    cell_count,
    output logic [ID_WIDTH-1:0]                            slot_handle
);

    localparam int NUM_CELLS = MAX_COLS * MAX_ROWS;
    localparam int CIDX_W    = sgpb_pkg::bits_for(NUM_CELLS);
    localparam int CNT_W     = sgpb_pkg::bits_for(SLOT_LIMIT + 1);
    localparam int HADDR_W   = CIDX_W + CNT_W;

    typedef enum logic [3:0] {
        B_IDLE,
        B_SWEEP,
        B_CNT_RD,
        B_CNT_WAIT,
        B_SRCH_RD,
        B_SRCH_CMP,
        B_LAST_RD,
        B_LAST_WAIT,
        B_SLOT_WAIT,
        B_DONE
    } bstate_t;

    bstate_t             state_reg;
    logic                init_reg;
    logic [CIDX_W-1:0]   sweep_reg;
    logic [1:0]          op_reg;
    logic [CIDX_W-1:0]   cidx_reg;
    logic [ID_WIDTH-1:0] id_reg;
    logic [CNT_W-1:0]    sel_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    idx_reg;

    sgpb_pkg::status_t   res_status_reg;
    logic [CIDX_W-1:0]   res_cidx_reg;
    logic [CNT_W-1:0]    res_cnt_reg;
    logic [ID_WIDTH-1:0] res_handle_reg;

    logic                out_valid_reg;
    sgpb_pkg::status_t   out_status_reg;
    logic [CIDX_W-1:0]   out_cidx_reg;
    logic [CNT_W-1:0]    out_cnt_reg;
    logic [ID_WIDTH-1:0] out_handle_reg;

    logic [CNT_W-1:0]    count_mem [NUM_CELLS];
    logic [ID_WIDTH-1:0] hnd_mem [NUM_CELLS * (2 ** CNT_W)];
    logic [CNT_W-1:0]    cnt_rdata_reg;
    logic [ID_WIDTH-1:0] hnd_rdata_reg;

    logic                cnt_we;
    logic [CIDX_W-1:0]   cnt_waddr;
    logic [CNT_W-1:0]    cnt_wdata;
    logic                hnd_we;
    logic [HADDR_W-1:0]  hnd_waddr;
    logic [ID_WIDTH-1:0] hnd_wdata;
    logic [HADDR_W-1:0]  hnd_raddr;

    logic [1:0]          c_op;
    logic                c_outside;
    logic [CIDX_W-1:0]   c_cidx;
    logic [ID_WIDTH-1:0] c_id;
    logic [CNT_W-1:0]    c_sel;
    logic [CNT_W-1:0]    cnt_inc;
    logic                out_free;

    assign {c_op, c_outside, c_cidx, c_id, c_sel} = cmd_data;

    assign cnt_inc  = (cnt_rdata_reg < CNT_W'(SLOT_LIMIT)) ? cnt_rdata_reg + 1'b1
                                                           : cnt_rdata_reg;
    assign out_free = !out_valid_reg || pop;
    assign cmd_pop  = (state_reg == B_IDLE) && !cmd_empty;
    assign init_busy = init_reg;

    assign empty       = !out_valid_reg;
    assign status      = out_status_reg;
    assign bin_index   = out_cidx_reg;
    assign cell_count  = out_cnt_reg;
    assign slot_handle = out_handle_reg;

    // Memory port control follows the engine state.
    always_comb
    begin
        cnt_we    = 1'b0;
        cnt_waddr = cidx_reg;
        cnt_wdata = '0;
        hnd_we    = 1'b0;
        hnd_waddr = {cidx_reg, cnt_rdata_reg};
        hnd_wdata = id_reg;
        hnd_raddr = {cidx_reg, idx_reg};
        case (state_reg)
            B_SWEEP:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = sweep_reg;
            end
            B_CNT_WAIT:
            begin
                hnd_raddr = {cidx_reg, sel_reg};
                if (op_reg == sgpb_pkg::REQ_REGISTER)
                begin
                    cnt_we    = 1'b1;
                    cnt_wdata = cnt_inc;
                    hnd_we    = 1'b1;
                end
            end
            B_LAST_RD:
            begin
                hnd_raddr = {cidx_reg, CNT_W'(cnt_reg - 1'b1)};
            end
            B_LAST_WAIT:
            begin
                cnt_we    = 1'b1;
                cnt_wdata = cnt_reg - 1'b1;
                hnd_we    = 1'b1;
                hnd_waddr = {cidx_reg, idx_reg};
                hnd_wdata = hnd_rdata_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            count_mem[cnt_waddr] <= cnt_wdata;
        end
        cnt_rdata_reg <= count_mem[cidx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (hnd_we)
        begin
            hnd_mem[hnd_waddr] <= hnd_wdata;
        end
        hnd_rdata_reg <= hnd_mem[hnd_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_SWEEP;
            init_reg      <= 1'b1;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == B_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE:
                begin
                    if (!cmd_empty)
                    begin
                        op_reg         <= c_op;
                        cidx_reg       <= c_cidx;
                        id_reg         <= c_id;
                        sel_reg        <= c_sel;
                        idx_reg        <= '0;
                        res_cnt_reg    <= '0;
                        res_handle_reg <= '0;
                        if (c_op == sgpb_pkg::REQ_CLEAR)
                        begin
                            res_status_reg <= sgpb_pkg::ST_OK;
                            res_cidx_reg   <= '0;
                            sweep_reg      <= '0;
                            state_reg      <= B_SWEEP;
                        end
                        else if (c_op == sgpb_pkg::REQ_REGISTER && c_outside)
                        begin
                            res_status_reg <= sgpb_pkg::ST_OUTSIDE;
                            res_cidx_reg   <= '0;
                            state_reg      <= B_DONE;
                        end
                        else
                        begin
                            res_status_reg <= sgpb_pkg::ST_OK;
                            res_cidx_reg   <= c_cidx;
                            state_reg      <= B_CNT_RD;
                        end
                    end
                end
                B_SWEEP:
                begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_reg == CIDX_W'(NUM_CELLS - 1))
                    begin
                        init_reg  <= 1'b0;
                        state_reg <= init_reg ? B_IDLE : B_DONE;
                    end
                end
                B_CNT_RD:
                begin
                    state_reg <= B_CNT_WAIT;
                end
                B_CNT_WAIT:
                begin
                    cnt_reg <= cnt_rdata_reg;
                    case (op_reg)
                        sgpb_pkg::REQ_REGISTER:
                        begin
                            res_cnt_reg <= cnt_inc;
                            state_reg   <= B_DONE;
                        end
                        sgpb_pkg::REQ_UNREGISTER:
                        begin
                            res_cnt_reg <= cnt_rdata_reg;
                            if (cnt_rdata_reg == '0)
                            begin
                                res_status_reg <= sgpb_pkg::ST_NOT_FOUND;
                                state_reg      <= B_DONE;
                            end
                            else
                            begin
                                state_reg <= B_SRCH_RD;
                            end
                        end
                        default:
                        begin
                            // Reads; a slot past the last one answers zero.
                            res_cnt_reg <= cnt_rdata_reg;
                            if ((CNT_W+1)'(sel_reg) <= (CNT_W+1)'(SLOT_LIMIT))
                            begin
                                state_reg <= B_SLOT_WAIT;
                            end
                            else
                            begin
                                state_reg <= B_DONE;
                            end
                        end
                    endcase
                end
                B_SRCH_RD:
                begin
                    state_reg <= B_SRCH_CMP;
                end
                B_SRCH_CMP:
                begin
                    if (hnd_rdata_reg == id_reg)
                    begin
                        state_reg <= B_LAST_RD;
                    end
                    else if (idx_reg == cnt_reg - 1'b1)
                    begin
                        res_status_reg <= sgpb_pkg::ST_NOT_FOUND;
                        state_reg      <= B_DONE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= B_SRCH_RD;
                    end
                end
                B_LAST_RD:
                begin
                    state_reg <= B_LAST_WAIT;
                end
                B_LAST_WAIT:
                begin
                    res_cnt_reg <= cnt_reg - 1'b1;
                    state_reg   <= B_DONE;
                end
                B_SLOT_WAIT:
                begin
                    res_handle_reg <= hnd_rdata_reg;
                    state_reg      <= B_DONE;
                end
                B_DONE:
                begin
                    if (out_free)
                    begin
                        out_status_reg <= res_status_reg;
                        out_cidx_reg   <= res_cidx_reg;
                        out_cnt_reg    <= res_cnt_reg;
                        out_handle_reg <= res_handle_reg;
                        state_reg      <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/spatial_grid_particle_binner_core.sv
// ============================================================================
// Spatial grid particle binner
// Bins particle handles into a two-dimensional uniform grid of cells.
// ============================================================================
//
//  channel   direction  handshake          beat contents
//  -------   ---------  -----------------  ------------------------------------------
//  request   in         push / full        req_type, pos_x, pos_y, particle_id, slot_sel
//  result    out        pop / empty        status, bin_index, cell_count, slot_handle
//  config    in         cfg_we             cfg_index, cfg_data (no wait, no read-back)
//
// The front end maps a position to a cell with two restoring dividers that retire one
// quotient bit per cycle; a request beat occupies it through load, 25 divide steps,
// classify, index multiply and hand-off, and no new beat is taken before the hand-off.
// The cell engine then reads the cell count, searches the handle slots one at a time
// for an unregister, moves the last handle into a freed slot, and for a clear zeroes
// every cell in turn; an outside register skips the stores. After reset the engine
// zeroes all MAX_COLS*MAX_ROWS counts, one cell a cycle, and full stays high until
// that pass is done. A two-entry queue between the halves and a one-beat result
// register let a waiting result stall the cell engine while new request beats are
// still taken until the queue fills and the front end cannot hand off.
// ============================================================================
module spatial_grid_particle_binner_core #(
    parameter int MAX_COLS   = sgpb_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS   = sgpb_pkg::MAX_ROWS_DEF,
    parameter int SLOT_LIMIT = sgpb_pkg::SLOT_LIMIT_DEF,
    parameter int ID_WIDTH   = sgpb_pkg::ID_WIDTH_DEF
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    // request side
    input  logic                                             push,
    output logic                                             full,
    input  logic [1:0]                                       req_type,
    input  logic [sgpb_pkg::POS_W-1:0]                       pos_x,
    input  logic [sgpb_pkg::POS_W-1:0]                       pos_y,
    input  logic [ID_WIDTH-1:0]                              particle_id,
    input  logic [sgpb_pkg::bits_for(SLOT_LIMIT+1)-1:0]      slot_sel,
    // result side
    output logic                                             empty,
    input  logic                                             pop,
    output logic [1:0]                                       status,
    output logic [sgpb_pkg::bits_for(MAX_COLS*MAX_ROWS)-1:0] bin_index,
    output logic [sgpb_pkg::bits_for(SLOT_LIMIT+1)-1:0]      cell_count,
    output logic [ID_WIDTH-1:0]                              slot_handle,
    // configuration
    input  logic                                             cfg_we,
    input  logic [sgpb_pkg::CFG_IDX_W-1:0]                   cfg_index,
    input  logic [sgpb_pkg::CFG_DATA_W-1:0]                  cfg_data
);

    localparam int CIDX_W = sgpb_pkg::bits_for(MAX_COLS * MAX_ROWS);
    localparam int CNT_W  = sgpb_pkg::bits_for(SLOT_LIMIT + 1);
    localparam int CMD_W  = 2 + 1 + CIDX_W + ID_WIDTH + CNT_W;

    logic [sgpb_pkg::POS_W-1:0] min_x_reg;
    logic [sgpb_pkg::POS_W-1:0] min_y_reg;
    logic [sgpb_pkg::CS_W-1:0]  cell_edge_reg;
    logic [sgpb_pkg::RES_W-1:0] res_x_reg;
    logic [sgpb_pkg::RES_W-1:0] res_y_reg;

    logic             front_busy;
    logic             init_busy;
    logic             cmd_push;
    logic [CMD_W-1:0] cmd_wdata;
    logic             cmd_full;
    logic             cmd_pop;
    logic [CMD_W-1:0] cmd_rdata;
    logic             cmd_empty;

    // The front end takes one request at a time, and nothing is taken while the
    // count store is being cleared after reset.
    assign full = front_busy || init_busy;

    // Configuration registers. Writes to indexes past the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg     <= sgpb_pkg::MIN_X_RST;
            min_y_reg     <= sgpb_pkg::MIN_Y_RST;
            cell_edge_reg <= sgpb_pkg::CELL_EDGE_RST;
            res_x_reg     <= sgpb_pkg::RES_X_RST;
            res_y_reg     <= sgpb_pkg::RES_Y_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sgpb_pkg::CFG_MIN_X:     min_x_reg     <= cfg_data;
                sgpb_pkg::CFG_MIN_Y:     min_y_reg     <= cfg_data;
                sgpb_pkg::CFG_CELL_EDGE: cell_edge_reg <= cfg_data[sgpb_pkg::CS_W-1:0];
                sgpb_pkg::CFG_RES_X:     res_x_reg     <= cfg_data[sgpb_pkg::RES_W-1:0];
                sgpb_pkg::CFG_RES_Y:     res_y_reg     <= cfg_data[sgpb_pkg::RES_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Front end: divide, classify and compute the linear cell index.
    sgpb_front #(
        .MAX_COLS   (MAX_COLS),
        .MAX_ROWS   (MAX_ROWS),
        .SLOT_LIMIT (SLOT_LIMIT),
        .ID_WIDTH   (ID_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push && !full),
        .busy        (front_busy),
        .req_type    (req_type),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .particle_id (particle_id),
        .slot_sel    (slot_sel),
        .min_x       (min_x_reg),
        .min_y       (min_y_reg),
        .cell_edge   (cell_edge_reg),
        .res_x       (res_x_reg),
        .res_y       (res_y_reg),
        .cmd_push    (cmd_push),
        .cmd_data    (cmd_wdata),
        .cmd_full    (cmd_full)
    );

    // Classified commands wait here for the cell engine.
    sgpb_queue #(
        .WIDTH (CMD_W),
        .DEPTH (sgpb_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_wdata),
        .q_full  (cmd_full),
        .rd_en   (cmd_pop),
        .rd_data (cmd_rdata),
        .q_empty (cmd_empty)
    );

    // Cell engine: count and handle stores, slot search and the result register.
    sgpb_back #(
        .MAX_COLS   (MAX_COLS),
        .MAX_ROWS   (MAX_ROWS),
        .SLOT_LIMIT (SLOT_LIMIT),
        .ID_WIDTH   (ID_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .init_busy   (init_busy),
        .cmd_data    (cmd_rdata),
        .cmd_empty   (cmd_empty),
        .cmd_pop     (cmd_pop),
        .empty       (empty),
        .pop         (pop),
        .status      (status),
        .bin_index   (bin_index),
        .cell_count  (cell_count),
        .slot_handle (slot_handle)
    );

endmodule
